### src/abkf_pkg.sv
// Shared types, microprogram and saturation helpers for the angle and bias Kalman filter.
package abkf_pkg;

	localparam int PROG_LEN = 29;
	localparam int PC_W = $clog2(PROG_LEN);

	typedef enum logic [1:0] {
		OP_ADD,
		OP_SUB,
		OP_MUL,
		OP_DIV
	} op_t;

	typedef enum logic [4:0] {
		R_RATE,
		R_ANGLE,
		R_BIAS,
		R_P00,
		R_P01,
		R_P10,
		R_P11,
		R_T,
		R_U,
		R_S,
		R_K0,
		R_K1,
		R_Y,
		R_MA,
		R_MR,
		R_DT,
		R_QA,
		R_QB,
		R_RN
	} reg_sel_t;

	typedef struct packed {
		op_t      op;
		reg_sel_t dst;
		reg_sel_t a;
		reg_sel_t b;
	} uop_t;

	typedef struct packed {
		logic start;
		logic div;
	} su_req_t;

	localparam logic [1:0] CFG_ANGLE_NOISE = 2'd0;
	localparam logic [1:0] CFG_BIAS_NOISE = 2'd1;
	localparam logic [1:0] CFG_MEAS_NOISE = 2'd2;

	function automatic uop_t prog(input logic [PC_W-1:0] pc);
		uop_t u;
		u = '{OP_ADD, R_T, R_T, R_T};
		case (pc)
			5'd0: u = '{OP_SUB, R_RATE, R_MR, R_BIAS};
			5'd1: u = '{OP_MUL, R_T, R_DT, R_RATE};
			5'd2: u = '{OP_ADD, R_ANGLE, R_ANGLE, R_T};
			5'd3: u = '{OP_MUL, R_U, R_DT, R_P11};
			5'd4: u = '{OP_SUB, R_T, R_U, R_P01};
			5'd5: u = '{OP_SUB, R_T, R_T, R_P10};
			5'd6: u = '{OP_ADD, R_T, R_T, R_QA};
			5'd7: u = '{OP_MUL, R_T, R_DT, R_T};
			5'd8: u = '{OP_ADD, R_P00, R_P00, R_T};
			5'd9: u = '{OP_SUB, R_P01, R_P01, R_U};
			5'd10: u = '{OP_SUB, R_P10, R_P10, R_U};
			5'd11: u = '{OP_MUL, R_T, R_QB, R_DT};
			5'd12: u = '{OP_ADD, R_P11, R_P11, R_T};
			5'd13: u = '{OP_ADD, R_S, R_P00, R_RN};
			5'd14: u = '{OP_DIV, R_K0, R_P00, R_S};
			5'd15: u = '{OP_DIV, R_K1, R_P10, R_S};
			5'd16: u = '{OP_SUB, R_Y, R_MA, R_ANGLE};
			5'd17: u = '{OP_MUL, R_T, R_K0, R_Y};
			5'd18: u = '{OP_ADD, R_ANGLE, R_ANGLE, R_T};
			5'd19: u = '{OP_MUL, R_T, R_K1, R_Y};
			5'd20: u = '{OP_ADD, R_BIAS, R_BIAS, R_T};
			5'd21: u = '{OP_MUL, R_T, R_K1, R_P00};
			5'd22: u = '{OP_SUB, R_P10, R_P10, R_T};
			5'd23: u = '{OP_MUL, R_T, R_K1, R_P01};
			5'd24: u = '{OP_SUB, R_P11, R_P11, R_T};
			5'd25: u = '{OP_MUL, R_T, R_K0, R_P00};
			5'd26: u = '{OP_SUB, R_P00, R_P00, R_T};
			5'd27: u = '{OP_MUL, R_T, R_K0, R_P01};
			5'd28: u = '{OP_SUB, R_P01, R_P01, R_T};
			default: u = '{OP_ADD, R_T, R_T, R_T};
		endcase
		return u;
	endfunction

	function automatic logic signed [31:0] sat_addsub(input logic signed [31:0] a,
			input logic signed [31:0] b, input logic sub);
		logic signed [32:0] s;
		s = sub ? (33'(a) - 33'(b)) : (33'(a) + 33'(b));
		if (s[32] != s[31]) begin
			return s[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
		end
		return s[31:0];
	endfunction

	function automatic logic signed [31:0] from_mag(input logic [63:0] m, input logic neg);
		logic [31:0] n;
		n = 32'(~m[31:0] + 32'd1);
		if (neg) begin
			if (m > 64'h0000_0000_8000_0000) begin
				return 32'sh8000_0000;
			end
			return n;
		end
		if (m > 64'h0000_0000_7fff_ffff) begin
			return 32'sh7fff_ffff;
		end
		return m[31:0];
	endfunction

	function automatic logic [31:0] mag32(input logic signed [31:0] v);
		return v[31] ? 32'(~v + 32'sd1) : v;
	endfunction

endpackage

### src/abkf_serial_unit.sv
// Bit-serial signed fixed-point multiplier and divider with rounding and saturation.
module abkf_serial_unit import abkf_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  su_req_t            req,
	input  logic signed [31:0] a,
	input  logic signed [31:0] b,
	output logic               done,
	output logic signed [31:0] res
);

	localparam int NW = 33 + FRAC_BITS;
	localparam int CW = $clog2(NW + 1);

	typedef enum logic [3:0] {
		SU_IDLE = 4'b0001,
		SU_MUL  = 4'b0010,
		SU_DIV  = 4'b0100,
		SU_FIN  = 4'b1000
	} su_state_t;

	su_state_t          state_q;
	logic [CW-1:0]      cnt_q;
	logic               neg_q;
	logic               div_q;
	logic [31:0]        mag_q;
	logic [31:0]        mb_q;
	logic [32:0]        hi_q;
	logic [NW-1:0]      lo_q;
	logic               done_q;
	logic signed [31:0] res_q;

	logic [32:0]        mul_sum;
	logic [32:0]        trial;
	logic               ge;
	logic [63:0]        rnd;
	logic signed [31:0] fin_val;
	logic [NW-1:0]      num0;

	always_comb begin
		mul_sum = hi_q + {1'b0, (mb_q[0] ? mag_q : 32'd0)};
		trial = {hi_q[31:0], lo_q[NW-1]};
		ge = trial >= {1'b0, mag_q};
		rnd = ({hi_q[31:0], lo_q[31:0]} + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
		fin_val = div_q ? from_mag(64'(lo_q), neg_q) : from_mag(rnd, neg_q);
		num0 = (NW'(mag32(a)) << FRAC_BITS) + NW'(mag32(b) >> 1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SU_IDLE;
			cnt_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				SU_IDLE: begin
					if (req.start) begin
						if (req.div && b == 32'sd0) begin
							done_q <= 1'b1;
						end else if (req.div) begin
							state_q <= SU_DIV;
							cnt_q <= CW'(NW);
						end else begin
							state_q <= SU_MUL;
							cnt_q <= CW'(32);
						end
					end
				end
				SU_MUL, SU_DIV: begin
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == CW'(1)) begin
						state_q <= SU_FIN;
					end
				end
				SU_FIN: begin
					state_q <= SU_IDLE;
					done_q <= 1'b1;
				end
				default: state_q <= SU_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			SU_IDLE: begin
				neg_q <= a[31] ^ b[31];
				div_q <= req.div;
				res_q <= '0;
				hi_q <= '0;
				if (req.div) begin
					mag_q <= mag32(b);
					lo_q <= num0;
				end else begin
					mag_q <= mag32(a);
					mb_q <= mag32(b);
					lo_q <= '0;
				end
			end
			SU_MUL: begin
				hi_q <= {1'b0, mul_sum[32:1]};
				lo_q[31:0] <= {mul_sum[0], lo_q[31:1]};
				mb_q <= {1'b0, mb_q[31:1]};
			end
			SU_DIV: begin
				hi_q <= ge ? (trial - {1'b0, mag_q}) : trial;
				lo_q <= {lo_q[NW-2:0], ge};
			end
			SU_FIN: begin
				res_q <= fin_val;
			end
			default: ;
		endcase
	end

	assign done = done_q;
	assign res = res_q;

endmodule

### src/angle_bias_kalman_filter_unit.sv
// Top level of the two-state angle and gyro bias Kalman filter.
// Each accepted sample runs a 29-step microprogram over one shared bit-serial unit: the
// seventeen additions and subtractions are done directly, while the ten multiplications
// and the two divisions run on the serial unit (a division skips the serial loop when
// the divisor is zero). The sample is captured when it is taken, and the result is then
// loaded into the output register; a stalled output holds the unit until that load. A new
// sample is taken once the previous result is in the output register.
module angle_bias_kalman_filter_unit import abkf_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [31:0] measured_angle,
	input  logic signed [31:0] measured_rate,
	input  logic [16:0]        time_step,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] angle_estimate,
	output logic signed [31:0] rate_estimate,
	output logic signed [31:0] bias_estimate,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [30:0]        cfg_data
);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_EXEC = 4'b0010,
		ST_WAIT = 4'b0100,
		ST_DONE = 4'b1000
	} state_t;

	state_t             state_q;
	logic [PC_W-1:0]    pc_q;
	logic [30:0]        qa_q, qb_q, rn_q;
	logic signed [31:0] rate_q, angle_q, bias_q, p00_q, p01_q, p10_q, p11_q;
	logic signed [31:0] t_q, u_q, s_q, k0_q, k1_q, y_q, ma_q, mr_q;
	logic [16:0]        dt_q;
	logic               out_valid_q;
	logic signed [31:0] out_angle_q, out_rate_q, out_bias_q;

	uop_t               uop;
	logic signed [31:0] opa, opb;
	logic               wb_en;
	logic signed [31:0] wb_val;
	logic               last;
	su_req_t            su_req;
	logic               su_done;
	logic signed [31:0] su_res;

	function automatic logic signed [31:0] pick(input reg_sel_t r,
			input logic signed [31:0] v_rate, v_angle, v_bias, v_p00, v_p01, v_p10,
			v_p11, v_t, v_u, v_s, v_k0, v_k1, v_y, v_ma, v_mr, v_dt, v_qa, v_qb, v_rn);
		logic signed [31:0] v;
		unique case (r)
			R_RATE: v = v_rate;
			R_ANGLE: v = v_angle;
			R_BIAS: v = v_bias;
			R_P00: v = v_p00;
			R_P01: v = v_p01;
			R_P10: v = v_p10;
			R_P11: v = v_p11;
			R_T: v = v_t;
			R_U: v = v_u;
			R_S: v = v_s;
			R_K0: v = v_k0;
			R_K1: v = v_k1;
			R_Y: v = v_y;
			R_MA: v = v_ma;
			R_MR: v = v_mr;
			R_DT: v = v_dt;
			R_QA: v = v_qa;
			R_QB: v = v_qb;
			R_RN: v = v_rn;
			default: v = '0;
		endcase
		return v;
	endfunction

	always_comb begin
		uop = prog(pc_q);
		opa = pick(uop.a, rate_q, angle_q, bias_q, p00_q, p01_q, p10_q, p11_q, t_q, u_q,
			s_q, k0_q, k1_q, y_q, ma_q, mr_q, 32'(dt_q), 32'(qa_q), 32'(qb_q), 32'(rn_q));
		opb = pick(uop.b, rate_q, angle_q, bias_q, p00_q, p01_q, p10_q, p11_q, t_q, u_q,
			s_q, k0_q, k1_q, y_q, ma_q, mr_q, 32'(dt_q), 32'(qa_q), 32'(qb_q), 32'(rn_q));
		su_req.start = (state_q == ST_EXEC) && (uop.op == OP_MUL || uop.op == OP_DIV);
		su_req.div = uop.op == OP_DIV;
		wb_en = 1'b0;
		wb_val = su_res;
		if (state_q == ST_EXEC && (uop.op == OP_ADD || uop.op == OP_SUB)) begin
			wb_en = 1'b1;
			wb_val = sat_addsub(opa, opb, uop.op == OP_SUB);
		end else if (state_q == ST_WAIT && su_done) begin
			wb_en = 1'b1;
		end
		last = pc_q == PC_W'(PROG_LEN - 1);
	end

	abkf_serial_unit #(
		.FRAC_BITS(FRAC_BITS)
	) u_serial (
		.clk(clk),
		.arst_n(arst_n),
		.req(su_req),
		.a(opa),
		.b(opb),
		.done(su_done),
		.res(su_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pc_q <= '0;
			qa_q <= 31'd66;
			qb_q <= 31'd197;
			rn_q <= 31'd1966;
			rate_q <= '0;
			angle_q <= '0;
			bias_q <= '0;
			p00_q <= '0;
			p01_q <= '0;
			p10_q <= '0;
			p11_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					CFG_ANGLE_NOISE: qa_q <= cfg_data;
					CFG_BIAS_NOISE: qb_q <= cfg_data;
					CFG_MEAS_NOISE: rn_q <= cfg_data;
					default: ;
				endcase
			end
			if (state_q == ST_DONE && (!out_valid_q || !out_stall)) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (wb_en) begin
				case (uop.dst)
					R_RATE: rate_q <= wb_val;
					R_ANGLE: angle_q <= wb_val;
					R_BIAS: bias_q <= wb_val;
					R_P00: p00_q <= wb_val;
					R_P01: p01_q <= wb_val;
					R_P10: p10_q <= wb_val;
					R_P11: p11_q <= wb_val;
					default: ;
				endcase
			end
			unique case (state_q)
				ST_IDLE: begin
					pc_q <= '0;
					if (in_valid) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					if (su_req.start) begin
						state_q <= ST_WAIT;
					end else if (last) begin
						state_q <= ST_DONE;
					end else begin
						pc_q <= pc_q + 1'b1;
					end
				end
				ST_WAIT: begin
					if (su_done) begin
						if (last) begin
							state_q <= ST_DONE;
						end else begin
							state_q <= ST_EXEC;
							pc_q <= pc_q + 1'b1;
						end
					end
				end
				ST_DONE: begin
					if (!out_valid_q || !out_stall) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) begin
			ma_q <= measured_angle;
			mr_q <= measured_rate;
			dt_q <= time_step;
		end
		if (wb_en) begin
			case (uop.dst)
				R_T: t_q <= wb_val;
				R_U: u_q <= wb_val;
				R_S: s_q <= wb_val;
				R_K0: k0_q <= wb_val;
				R_K1: k1_q <= wb_val;
				R_Y: y_q <= wb_val;
				default: ;
			endcase
		end
		if (state_q == ST_DONE && (!out_valid_q || !out_stall)) begin
			out_angle_q <= angle_q;
			out_rate_q <= rate_q;
			out_bias_q <= bias_q;
		end
	end

	assign in_stall = state_q != ST_IDLE;
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign angle_estimate = out_angle_q;
	assign rate_estimate = out_rate_q;
	assign bias_estimate = out_bias_q;

endmodule

### tb/tb_angle_bias_kalman_filter_unit.sv
// Self-checking testbench for the angle and gyro bias Kalman filter unit.
module tb_angle_bias_kalman_filter_unit import abkf_pkg::*;;

	localparam int FB = 16;
	localparam longint CYCLE_LIMIT = 2000000;

	typedef struct packed {
		logic signed [31:0] angle;
		logic signed [31:0] rate;
		logic [16:0]        dt;
	} sample_t;

	typedef struct packed {
		logic signed [31:0] angle;
		logic signed [31:0] rate;
		logic signed [31:0] bias;
	} estimate_t;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic signed [31:0] measured_angle;
	logic signed [31:0] measured_rate;
	logic [16:0] time_step;
	logic out_valid;
	logic out_stall;
	logic signed [31:0] angle_estimate;
	logic signed [31:0] rate_estimate;
	logic signed [31:0] bias_estimate;
	logic cfg_valid;
	logic cfg_ready;
	logic [1:0] cfg_index;
	logic [30:0] cfg_data;

	sample_t pending_samples[$];
	estimate_t expected_estimates[$];
	int mismatches = 0;
	longint cycles = 0;
	int send_gap = 0;
	int stall_left = 0;
	bit in_taken = 1'b0;

	logic signed [31:0] q_angle, q_bias, r_noise;
	logic signed [31:0] est_angle, est_bias, est_rate;
	logic signed [31:0] cov[4];

	angle_bias_kalman_filter_unit i_dut (.*);

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	function automatic logic signed [31:0] clamp(input logic signed [65:0] v);
		if (v > 66'sh7fff_ffff) return 32'sh7fff_ffff;
		if (v < -66'sh8000_0000) return 32'sh8000_0000;
		return v[31:0];
	endfunction

	function automatic logic signed [31:0] add_s(input logic signed [31:0] a, b);
		return clamp(66'(a) + 66'(b));
	endfunction

	function automatic logic signed [31:0] sub_s(input logic signed [31:0] a, b);
		return clamp(66'(a) - 66'(b));
	endfunction

	function automatic logic signed [31:0] signed_mag(input logic [65:0] m, input logic neg);
		logic signed [65:0] v;
		v = neg ? -$signed(m) : $signed(m);
		return clamp(v);
	endfunction

	function automatic logic signed [31:0] mul_s(input logic signed [31:0] a, b);
		logic signed [65:0] p;
		logic [65:0] m;
		p = 66'(a) * 66'(b);
		m = p < 0 ? 66'(-p) : 66'(p);
		m = (m + (66'd1 << (FB - 1))) >> FB;
		return signed_mag(m, p < 0);
	endfunction

	function automatic logic signed [31:0] div_s(input logic signed [31:0] a, b);
		logic [65:0] num, den, q;
		if (b == 0) return 0;
		num = (a < 0 ? 66'(-66'(a)) : 66'(a)) << FB;
		den = b < 0 ? 66'(-66'(b)) : 66'(b);
		q = (num + den / 2) / den;
		return signed_mag(q, (a < 0) != (b < 0));
	endfunction

	function automatic estimate_t filter_step(input sample_t s);
		logic signed [31:0] dt, t, u, p00, p01, p10, p11, sv, k0, k1, y;
		estimate_t e;
		dt = 32'(s.dt);
		p00 = cov[0]; p01 = cov[1]; p10 = cov[2]; p11 = cov[3];
		est_rate = sub_s(s.rate, est_bias);
		est_angle = add_s(est_angle, mul_s(dt, est_rate));
		u = mul_s(dt, p11);
		t = add_s(sub_s(sub_s(u, p01), p10), q_angle);
		p00 = add_s(p00, mul_s(dt, t));
		p01 = sub_s(p01, u);
		p10 = sub_s(p10, u);
		p11 = add_s(p11, mul_s(q_bias, dt));
		sv = add_s(p00, r_noise);
		k0 = div_s(p00, sv);
		k1 = div_s(p10, sv);
		y = sub_s(s.angle, est_angle);
		est_angle = add_s(est_angle, mul_s(k0, y));
		est_bias = add_s(est_bias, mul_s(k1, y));
		cov[0] = sub_s(p00, mul_s(k0, p00));
		cov[1] = sub_s(p01, mul_s(k0, p01));
		cov[2] = sub_s(p10, mul_s(k1, p00));
		cov[3] = sub_s(p11, mul_s(k1, p01));
		e.angle = est_angle; e.rate = est_rate; e.bias = est_bias;
		return e;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got, exp);
		$display("mismatch %s: got %h expected %h", what, got, exp);
		mismatches++;
	endtask

	task automatic write_register(input logic [1:0] idx, input logic [30:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
		case (idx)
			CFG_ANGLE_NOISE: q_angle = {1'b0, val};
			CFG_BIAS_NOISE:  q_bias = {1'b0, val};
			CFG_MEAS_NOISE:  r_noise = {1'b0, val};
			default: ;
		endcase
	endtask

	task automatic queue_sample(input logic [31:0] a, r, input logic [16:0] dt);
		sample_t s;
		s.angle = a; s.rate = r; s.dt = dt;
		pending_samples.push_back(s);
	endtask

	task automatic drain;
		while (pending_samples.size() != 0 || expected_estimates.size() != 0) @(posedge clk);
		repeat (600) @(posedge clk);
	endtask

	function automatic logic [16:0] rand_dt;
		case ($urandom_range(0, 9))
			0: return 17'($urandom_range(0, 131071));
			1: return 17'd0;
			default: return 17'($urandom_range(0, 2000));
		endcase
	endfunction

	function automatic logic [31:0] rand_word;
		case ($urandom_range(0, 5))
			0: return $urandom;
			1: return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
			default: return 32'($signed(32'($urandom_range(0, 2000000))) - 1000000);
		endcase
	endfunction

	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (in_taken) begin
			in_taken = 1'b0;
			send_gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 8);
			in_valid <= 1'b0;
		end else if (!in_valid && pending_samples.size() != 0) begin
			if (send_gap > 0) begin
				send_gap--;
			end else begin
				measured_angle <= pending_samples[0].angle;
				measured_rate <= pending_samples[0].rate;
				time_step <= pending_samples[0].dt;
				in_valid <= 1'b1;
			end
		end
		if (arst_n) begin
			if (stall_left > 0) begin
				stall_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		estimate_t e;
		cycles++;
		if (in_valid && !in_stall && arst_n) begin
			in_taken = 1'b1;
			expected_estimates.push_back(filter_step(pending_samples.pop_front()));
		end
		if (out_valid && !out_stall && arst_n) begin
			stall_left = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 8);
			if (expected_estimates.size() == 0) begin
				report_mismatch("unexpected word", angle_estimate, 0);
			end else begin
				e = expected_estimates.pop_front();
				if (angle_estimate !== e.angle) report_mismatch("angle", angle_estimate, e.angle);
				if (rate_estimate !== e.rate) report_mismatch("rate", rate_estimate, e.rate);
				if (bias_estimate !== e.bias) report_mismatch("bias", bias_estimate, e.bias);
			end
		end
		if (cycles > CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		out_stall = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		measured_angle = '0;
		measured_rate = '0;
		time_step = '0;
		q_angle = 66; q_bias = 197; r_noise = 1966;
		est_angle = 0; est_bias = 0; est_rate = 0;
		for (int i = 0; i < 4; i++) cov[i] = 0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Sample one has zero covariance, dt and measurement noise, so its gains are zero.
		write_register(CFG_MEAS_NOISE, 31'd0);
		write_register(CFG_ANGLE_NOISE, 31'd0);
		queue_sample(32'h0001_0000, 32'h0000_8000, 17'd0);
		queue_sample(32'h7fff_ffff, 32'h7fff_ffff, 17'h1ffff);
		queue_sample(32'h8000_0000, 32'h8000_0000, 17'h1ffff);
		drain();
		write_register(CFG_ANGLE_NOISE, 31'h7fff_ffff);
		write_register(CFG_BIAS_NOISE, 31'h7fff_ffff);
		write_register(CFG_MEAS_NOISE, 31'h7fff_ffff);
		queue_sample(32'h8000_0000, 32'h7fff_ffff, 17'h10000);
		queue_sample(32'h7fff_ffff, 32'h8000_0000, 17'h1ffff);
		queue_sample(32'hffff_ffff, 32'h0000_0001, 17'd1);
		queue_sample(32'h5555_5555, 32'haaaa_aaaa, 17'h0aaaa);
		queue_sample(32'haaaa_aaaa, 32'h5555_5555, 17'h15555);
		drain();
		write_register(CFG_ANGLE_NOISE, 31'd66);
		write_register(CFG_BIAS_NOISE, 31'd197);
		write_register(CFG_MEAS_NOISE, 31'd1966);
		for (int i = 0; i < 8; i++) queue_sample(32'h0002_0000, 32'h0000_1000, 17'd655);
		drain();

		for (int ph = 0; ph < 4; ph++) begin
			write_register(CFG_ANGLE_NOISE, ph == 3 ? 31'd0 : 31'($urandom_range(0, 5000)));
			write_register(CFG_BIAS_NOISE, ph == 2 ? 31'h7fff_ffff : 31'($urandom));
			write_register(CFG_MEAS_NOISE, ph == 1 ? 31'd0 : 31'($urandom_range(0, 200000)));
			for (int i = 0; i < 100; i++) queue_sample(rand_word(), rand_word(), rand_dt());
			drain();
		end

		if (mismatches == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
